// ===== src/fpa_pkg.sv =====
// Shared types, opcodes and constants of the Q24.8 fixed-point ALU.
package fpa_pkg;

	// Default number of fraction bits.
	localparam int FRAC_BITS_DEF = 8;

	// Stream widths: tdata packed from the lowest bit up, padded to bytes.
	localparam int IN_W  = 72;
	localparam int OUT_W = 40;

	// Depth of the queue between the front and the back.
	localparam int QDEPTH = 2;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_MUL     = 4'd2,
		OP_DIV     = 4'd3,
		OP_GT      = 4'd4,
		OP_LT      = 4'd5,
		OP_GE      = 4'd6,
		OP_LE      = 4'd7,
		OP_EQ      = 4'd8,
		OP_NE      = 4'd9,
		OP_MIN     = 4'd10,
		OP_MAX     = 4'd11,
		OP_INC     = 4'd12,
		OP_DEC     = 4'd13,
		OP_TOINT   = 4'd14,
		OP_FROMINT = 4'd15
	} op_t;

	// How the back finishes an item.
	typedef enum logic [1:0] {
		K_SIMPLE = 2'd0,
		K_MUL    = 2'd1,
		K_DIV    = 2'd2
	} kind_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] res;
		logic        cmp;
		logic        dz;
		logic        neg;
		logic [31:0] ma;
		logic [31:0] mb;
	} item_t;

endpackage

// ===== src/fpa_front.sv =====
// Front end: accepts input transactions, decodes the opcode and finishes the simple operations.
module fpa_front #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [fpa_pkg::IN_W-1:0]  s_tdata,
	output logic                      item_valid,
	input  logic                      item_ready,
	output fpa_pkg::item_t            item
);

	fpa_pkg::op_t       op;
	logic signed [31:0] a;
	logic signed [31:0] b;
	logic               lt;
	logic               gt;
	logic               eq;
	fpa_pkg::item_t     d;
	logic               v_q;
	fpa_pkg::item_t     item_q;

	assign op = fpa_pkg::op_t'(s_tdata[3:0]);
	assign a  = s_tdata[35:4];
	assign b  = s_tdata[67:36];
	assign lt = a < b;
	assign gt = a > b;
	assign eq = a == b;

	// Decode and compute everything that needs no multiplier or divider.
	always_comb begin
		d      = '0;
		d.kind = fpa_pkg::K_SIMPLE;
		d.neg  = a[31] ^ b[31];
		d.ma   = a[31] ? (~a + 32'd1) : a;
		d.mb   = b[31] ? (~b + 32'd1) : b;
		unique case (op)
			fpa_pkg::OP_ADD:     d.res = a + b;
			fpa_pkg::OP_SUB:     d.res = a - b;
			fpa_pkg::OP_MUL:     d.kind = fpa_pkg::K_MUL;
			fpa_pkg::OP_DIV: begin
				if (b == 32'sd0) begin
					d.res = 32'hFFFF_FFFF << FRAC_BITS;
					d.dz  = 1'b1;
				end else begin
					d.kind = fpa_pkg::K_DIV;
				end
			end
			fpa_pkg::OP_GT:      d.cmp = gt;
			fpa_pkg::OP_LT:      d.cmp = lt;
			fpa_pkg::OP_GE:      d.cmp = !lt;
			fpa_pkg::OP_LE:      d.cmp = !gt;
			fpa_pkg::OP_EQ:      d.cmp = eq;
			fpa_pkg::OP_NE:      d.cmp = !eq;
			fpa_pkg::OP_MIN:     d.res = lt ? a : b;
			fpa_pkg::OP_MAX:     d.res = gt ? a : b;
			fpa_pkg::OP_INC:     d.res = a + 32'sd1;
			fpa_pkg::OP_DEC:     d.res = a - 32'sd1;
			fpa_pkg::OP_TOINT:   d.res = a >>> FRAC_BITS;
			fpa_pkg::OP_FROMINT: d.res = a << FRAC_BITS;
			default:             d.res = '0;
		endcase
	end

	// The holding register refills whenever it is empty or being drained.
	assign s_tready = !v_q || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (s_tready) begin
			v_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q <= d;
		end
	end

	assign item_valid = v_q;
	assign item       = item_q;

endmodule

// ===== src/fpa_fifo.sv =====
// Short queue that decouples the front end from the arithmetic back end.
module fpa_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fpa_pkg::item_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output fpa_pkg::item_t out_item
);

	localparam int AW = (fpa_pkg::QDEPTH > 1) ? $clog2(fpa_pkg::QDEPTH) : 1;

	fpa_pkg::item_t mem [fpa_pkg::QDEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;
	logic           push;
	logic           pop;

	assign in_ready  = cnt_q != (AW+1)'(fpa_pkg::QDEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(fpa_pkg::QDEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(fpa_pkg::QDEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= in_item;
		end
	end

endmodule

// ===== src/fpa_back.sv =====
// Back end: pipelined multiplier with rounding, radix-2 divider pipeline and output register.
module fpa_back #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  fpa_pkg::item_t            in_item,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [fpa_pkg::OUT_W-1:0] m_tdata
);

	// Width of the rounded dividend 2*|a|*2^F + |b|, one quotient bit per stage.
	localparam int NW = FRAC_BITS + 33;

	logic              adv;
	logic              v_q    [NW+1];
	fpa_pkg::kind_t    kind_q [NW+1];
	logic [31:0]       res_q  [NW+1];
	logic              cmp_q  [NW+1];
	logic              dz_q   [NW+1];
	logic              neg_q  [NW+1];
	logic [NW-1:0]     num_q  [NW+1];
	logic [32:0]       den_q  [NW+1];
	logic [32:0]       rem_q  [NW+1];
	logic [NW-1:0]     quo_q  [NW+1];
	logic [63:0]       prod_s1;
	logic [63:0]       rsum;
	logic [31:0]       mul_mag;
	logic [31:0]       mul_res;
	logic              out_v_q;
	logic [31:0]       out_res_q;
	logic              out_cmp_q;
	logic              out_dz_q;

	// The whole pipeline moves together when the output register can take a result.
	assign adv      = !out_v_q || m_tready;
	assign in_ready = adv;

	// Multiply rounding: add one half LSB of the result, then drop the fraction.
	assign rsum    = prod_s1 + (64'd1 << (FRAC_BITS - 1));
	assign mul_mag = rsum[FRAC_BITS +: 32];
	assign mul_res = neg_q[0] ? (~mul_mag + 32'd1) : mul_mag;

	// Entry stage: product of the magnitudes and the divider's starting values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q[0] <= in_item.kind;
			res_q[0]  <= in_item.res;
			cmp_q[0]  <= in_item.cmp;
			dz_q[0]   <= in_item.dz;
			neg_q[0]  <= in_item.neg;
			prod_s1   <= 64'(in_item.ma) * 64'(in_item.mb);
			num_q[0]  <= {in_item.ma, {(FRAC_BITS + 1){1'b0}}} + NW'(in_item.mb);
			den_q[0]  <= {in_item.mb, 1'b0};
			rem_q[0]  <= '0;
			quo_q[0]  <= '0;
		end
	end

	// Divider stages: one restoring step each, dividend bits taken from the top.
	for (genvar k = 1; k <= NW; k++) begin : g_div
		logic [33:0] cand;
		logic        ge;

		assign cand = {rem_q[k-1], num_q[k-1][NW-1]};
		assign ge   = cand >= {1'b0, den_q[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (adv) begin
				v_q[k] <= v_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				kind_q[k] <= kind_q[k-1];
				res_q[k]  <= (k == 1 && kind_q[k-1] == fpa_pkg::K_MUL) ? mul_res : res_q[k-1];
				cmp_q[k]  <= cmp_q[k-1];
				dz_q[k]   <= dz_q[k-1];
				neg_q[k]  <= neg_q[k-1];
				num_q[k]  <= num_q[k-1] << 1;
				den_q[k]  <= den_q[k-1];
				rem_q[k]  <= ge ? 33'(cand - {1'b0, den_q[k-1]}) : cand[32:0];
				quo_q[k]  <= {quo_q[k-1][NW-2:0], ge};
			end
		end
	end

	// Output register: the quotient is signed and wrapped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_q[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (kind_q[NW] == fpa_pkg::K_DIV) begin
				out_res_q <= neg_q[NW] ? (~quo_q[NW][31:0] + 32'd1) : quo_q[NW][31:0];
			end else begin
				out_res_q <= res_q[NW];
			end
			out_cmp_q <= cmp_q[NW];
			out_dz_q  <= dz_q[NW];
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'b0, out_dz_q, out_cmp_q, out_res_q};

endmodule

// ===== src/fixed_point_q24_8_alu.sv =====
// Top level of the signed 32-bit fixed-point ALU.
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits: add, subtract, multiply and
// divide (rounded half away from zero), the six compares, min, max, increment, decrement and
// integer conversions, all wrapping to 32 bits; divide by zero gives -1.0 and raises a flag.
// It takes one transaction every cycle while results are being taken; when the output is
// held off the back end stalls as a whole, the queue fills and the input then stalls too.
// Every operation passes through the radix-2 divider pipeline of FRAC_BITS + 33 stages, so
// that results leave in order.
module fixed_point_q24_8_alu #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [fpa_pkg::IN_W-1:0]  s_tdata,  // op[3:0], a_raw[35:4], b_raw[67:36], zero pad
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [fpa_pkg::OUT_W-1:0] m_tdata   // result_raw[31:0], compare_true[32],
	                                            // divide_by_zero[33], zero pad
);

	logic           f_valid;
	logic           f_ready;
	fpa_pkg::item_t f_item;
	logic           q_valid;
	logic           q_ready;
	fpa_pkg::item_t q_item;

	fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	fpa_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_item  (q_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== tb/sv/tb_fixed_point_q24_8_alu.sv =====
// Self-checking testbench of the Q24.8 fixed-point ALU over its stream ports.
`timescale 1ns / 1ps

module tb_fixed_point_q24_8_alu;

	localparam int FB        = fpa_pkg::FRAC_BITS_DEF;
	localparam int N_RANDOM  = 800;
	localparam int QUIET_AT  = 700;   // no idling once this many random items are in
	localparam int TAIL_CYC  = 2 * (FB + 37) + 20;
	localparam int WD_LIMIT  = 3000;
	localparam int HOLD_CYC  = 300;

	typedef struct packed {
		fpa_pkg::op_t op;
		logic [31:0]  a;
		logic [31:0]  b;
	} alu_op_t;

	typedef struct packed {
		logic [31:0] res;
		logic        cmp;
		logic        dz;
	} alu_res_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [fpa_pkg::IN_W-1:0]     s_tdata;   // op[3:0], a_raw[35:4], b_raw[67:36], zero pad
	logic                         m_tvalid;
	logic                         m_tready;
	logic [fpa_pkg::OUT_W-1:0]    m_tdata;   // result_raw[31:0], compare_true[32],
	                                         // divide_by_zero[33], zero pad

	alu_op_t  pending_ops[$];
	alu_res_t expected_res[$];
	int       n_errors;
	int       n_sent;
	int       n_checked;
	int       n_random_in;
	bit       hold_done;

	fixed_point_q24_8_alu #(.FRAC_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Clock generation.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Magnitude of a signed 32-bit value as a 64-bit unsigned number.
	function automatic logic [63:0] magnitude(logic signed [31:0] v);
		logic signed [63:0] w;
		w = v;
		return (w < 0) ? -w : w;
	endfunction

	// Predicted outcome of one ALU operation.
	function automatic alu_res_t alu_predict(alu_op_t t);
		alu_res_t r;
		logic signed [31:0] sa;
		logic signed [31:0] sb;
		logic [63:0] m;
		logic [63:0] d;
		logic [63:0] q;
		logic neg;
		sa = t.a;
		sb = t.b;
		r = '0;
		neg = sa[31] != sb[31];
		case (t.op)
			fpa_pkg::OP_ADD: r.res = t.a + t.b;
			fpa_pkg::OP_SUB: r.res = t.a - t.b;
			fpa_pkg::OP_MUL: begin
				m = magnitude(sa) * magnitude(sb);
				q = (m + (64'd1 << (FB - 1))) >> FB;
				r.res = neg ? 32'(-q) : q[31:0];
			end
			fpa_pkg::OP_DIV: begin
				if (t.b == 32'd0) begin
					r.res = 32'hFFFF_FFFF << FB;
					r.dz = 1'b1;
				end else begin
					m = magnitude(sa) << FB;
					d = magnitude(sb);
					q = (2 * m + d) / (2 * d);
					r.res = neg ? 32'(-q) : q[31:0];
				end
			end
			fpa_pkg::OP_GT: r.cmp = sa > sb;
			fpa_pkg::OP_LT: r.cmp = sa < sb;
			fpa_pkg::OP_GE: r.cmp = sa >= sb;
			fpa_pkg::OP_LE: r.cmp = sa <= sb;
			fpa_pkg::OP_EQ: r.cmp = sa == sb;
			fpa_pkg::OP_NE: r.cmp = sa != sb;
			fpa_pkg::OP_MIN: r.res = (sa < sb) ? t.a : t.b;
			fpa_pkg::OP_MAX: r.res = (sa > sb) ? t.a : t.b;
			fpa_pkg::OP_INC: r.res = t.a + 32'd1;
			fpa_pkg::OP_DEC: r.res = t.a - 32'd1;
			fpa_pkg::OP_TOINT: r.res = sa >>> FB;
			default: r.res = t.a << FB;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return 32'($signed($urandom_range(0, 2047)) - 1024);
			2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			3: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 16);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_op(fpa_pkg::op_t o, logic [31:0] a, logic [31:0] b);
		pending_ops.push_back('{op: o, a: a, b: b});
	endtask

	// Driver: offers queued operations, with idle bursts until the quiet stretch.
	always @(posedge clk or negedge arst_n) begin
		int gap;
		alu_op_t t;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				t.op = fpa_pkg::op_t'(s_tdata[3:0]);
				t.a  = s_tdata[35:4];
				t.b  = s_tdata[67:36];
				expected_res.push_back(alu_predict(t));
				n_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap == 0 && n_random_in < QUIET_AT && $urandom_range(0, 9) == 0)
					gap = $urandom_range(1, 8);
				if (gap > 0) begin
					gap--;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					t = pending_ops.pop_front();
					s_tdata  <= {4'd0, t.b, t.a, 4'(t.op)};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transaction and shapes back-pressure.
	always @(posedge clk or negedge arst_n) begin
		int gap;
		int hold;
		alu_res_t e;
		alu_res_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
			gap = 0;
			hold = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{res: m_tdata[31:0], cmp: m_tdata[32], dz: m_tdata[33]};
				if (expected_res.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					n_errors++;
				end else begin
					e = expected_res.pop_front();
					if (got.res !== e.res) begin
						$display("%0t: result_raw expected %h actual %h", $time, e.res, got.res);
						n_errors++;
					end
					if (got.cmp !== e.cmp) begin
						$display("%0t: compare_true expected %b actual %b", $time, e.cmp, got.cmp);
						n_errors++;
					end
					if (got.dz !== e.dz) begin
						$display("%0t: divide_by_zero expected %b actual %b", $time, e.dz, got.dz);
						n_errors++;
					end
				end
				n_checked++;
			end
			// One long hold-off so that the pipeline fills and stalls its input.
			if (!hold_done && n_checked == 200) begin
				hold_done = 1'b1;
				hold = HOLD_CYC;
			end
			if (gap == 0 && hold == 0 && n_random_in < QUIET_AT && $urandom_range(0, 9) == 0)
				gap = $urandom_range(1, 8);
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles in which no transaction is accepted on either side.
	always @(posedge clk) begin
		int idle;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle = 0;
		else
			idle++;
		if (idle >= WD_LIMIT) begin
			$display("fixed_point_q24_8_alu verification failed");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		alu_op_t t;
		n_random_in = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, wrapping, rounding ties and divide by zero.
		push_op(fpa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1);
		push_op(fpa_pkg::OP_SUB, 32'h8000_0000, 32'd1);
		push_op(fpa_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_op(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
		push_op(fpa_pkg::OP_MUL, 32'd1, 32'd128);
		push_op(fpa_pkg::OP_MUL, 32'hFFFF_FFFF, 32'd128);
		push_op(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FF00);
		push_op(fpa_pkg::OP_DIV, 32'd1, 32'd512);
		push_op(fpa_pkg::OP_DIV, 32'hFFFF_FFFF, 32'd512);
		push_op(fpa_pkg::OP_DIV, 32'h1234_5678, 32'd0);
		push_op(fpa_pkg::OP_GT, 32'h7FFF_FFFF, 32'h8000_0000);
		push_op(fpa_pkg::OP_LT, 32'h7FFF_FFFF, 32'h8000_0000);
		push_op(fpa_pkg::OP_GE, 32'd5, 32'd5);
		push_op(fpa_pkg::OP_LE, 32'd5, 32'd5);
		push_op(fpa_pkg::OP_EQ, 32'h8000_0000, 32'h8000_0000);
		push_op(fpa_pkg::OP_NE, 32'd0, 32'd0);
		push_op(fpa_pkg::OP_MIN, 32'hFFFF_FFFF, 32'd1);
		push_op(fpa_pkg::OP_MAX, 32'hFFFF_FFFF, 32'd1);
		push_op(fpa_pkg::OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		push_op(fpa_pkg::OP_DEC, 32'h8000_0000, 32'hFFFF_FFFF);
		push_op(fpa_pkg::OP_TOINT, 32'hFFFF_FF01, 32'd0);
		push_op(fpa_pkg::OP_TOINT, 32'h8000_0000, 32'd0);
		push_op(fpa_pkg::OP_FROMINT, 32'h0080_0001, 32'd0);
		push_op(fpa_pkg::OP_FROMINT, 32'hFFFF_FFFF, 32'd0);

		// The sender pauses here until every directed result has come back.
		while (pending_ops.size() != 0 || s_tvalid || expected_res.size() != 0)
			@(posedge clk);

		// Random operations, fed a few at a time so the count that ends idle bursts tracks progress.
		while (n_random_in < N_RANDOM) begin
			if (pending_ops.size() < 4) begin
				t.op = fpa_pkg::op_t'($urandom_range(0, 15));
				t.a = rand_operand();
				t.b = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_operand();
				if ($urandom_range(0, 15) == 0)
					t.b = t.a;
				pending_ops.push_back(t);
				n_random_in++;
			end else begin
				@(posedge clk);
			end
		end

		while (pending_ops.size() != 0 || s_tvalid || expected_res.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		$display("Covered %0d operations over all sixteen opcodes, %0d results checked,",
			n_sent, n_checked);
		$display("with idle bursts, a long output stall and a full drain between phases.");
		if (n_errors == 0 && expected_res.size() == 0) begin
			$display("fixed_point_q24_8_alu verification clean");
		end else begin
			$display("fixed_point_q24_8_alu verification failed");
		end
		$finish;
	end

endmodule
